### hdl/tsw_pkg.sv
// Shared types and constants of the text terminal screen writer.
package tsw_pkg;

	// command codes carried in s_tuser
	localparam logic [2:0] FN_PUT    = 3'd0;
	localparam logic [2:0] FN_SETCUR = 3'd1;
	localparam logic [2:0] FN_CLS    = 3'd2;
	localparam logic [2:0] FN_CLL    = 3'd3;
	localparam logic [2:0] FN_READ   = 3'd4;

	// character codes
	localparam logic [7:0] CHAR_FIRST = 8'd32;   // space, first printable
	localparam logic [7:0] CHAR_TILDE = 8'd126;  // last printable
	localparam logic [7:0] CHAR_NL    = 8'd10;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [6:0] CELL_SPACE = 7'd32;
	localparam logic [6:0] CELL_NL    = 7'd10;
	localparam logic [7:0] TAB_STEP   = 8'd10;
	// floor(x/10) == (x*205)>>11 for every 7-bit x
	localparam logic [14:0] TAB_RECIP = 15'd205;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FILL,
		ST_SCROLL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic fill_step;
		logic scroll_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic dec_fill;
		logic dec_scroll;
		logic scroll_pend;
		logic fill_last;
		logic scroll_done;
		logic out_free;
	} dp_stat_t;

endpackage

### hdl/tsw_ctrl.sv
// Sequencer of the text terminal screen writer: command, fill, scroll and result phases.
module tsw_ctrl
	import tsw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (stat.fill_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					priority if (stat.dec_fill) state_d = ST_FILL;
					else if (stat.dec_scroll)   state_d = ST_SCROLL;
					else                        state_d = ST_DONE;
				end
			end
			ST_FILL: begin
				if (stat.fill_last) state_d = stat.scroll_pend ? ST_SCROLL : ST_DONE;
			end
			ST_SCROLL: begin
				if (stat.scroll_done) state_d = ST_FILL;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// outputs
	always_comb begin
		s_tready        = (state_q == ST_IDLE);
		cmd.accept      = (state_q == ST_IDLE) && s_tvalid;
		cmd.fill_step   = (state_q == ST_INIT) || (state_q == ST_FILL);
		cmd.scroll_step = (state_q == ST_SCROLL);
		cmd.out_load    = (state_q == ST_DONE) && stat.out_free;
	end

`ifndef ASSERT_OFF
	// one command at a time: no beat right after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !s_tready) else $error("beat accepted back to back");
	// scroll only runs with a pending scroll request
	a_scroll_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL) |-> stat.scroll_pend) else $error("scroll without request");
	// a fill ending in the result phase leaves no scroll behind
	a_fill_exit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FILL) && stat.fill_last && !stat.scroll_pend) |=>
		(state_q == ST_DONE)) else $error("fill exit lost");
`endif

endmodule

### hdl/tsw_dp.sv
// Datapath of the text terminal screen writer: decode, cursor, character store, result register.
module tsw_dp
	import tsw_pkg::*;
#(
	parameter int ROWS = 20,
	parameter int COLS = 61
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [23:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [23:0] m_tdata,
	input  ctrl_cmd_t   cmd,
	output dp_stat_t    stat
);

	localparam int TOTAL = ROWS * COLS;
	localparam int CW = $clog2(COLS);
	localparam int RW = $clog2(ROWS);
	localparam int IW = $clog2(TOTAL);
	localparam int AW = $clog2(TOTAL + 1);
	localparam logic [7:0] COLS_B = 8'(COLS);
	localparam logic [7:0] ROWS_B = 8'(ROWS);

	logic [6:0]    mem [TOTAL];
	logic [6:0]    rdata_q;

	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [IW-1:0] fill_addr_q;
	logic [AW-1:0] fill_cnt_q;
	logic          scroll_pend_q;
	logic [AW-1:0] src_q;
	logic          vld_s1;
	logic [IW-1:0] dst_s1;
	logic          use_mem_q;
	logic [6:0]    cell_q;
	logic          m_tvalid_q;
	logic [23:0]   m_tdata_q;

	logic [7:0]    ch, ca, ra;
	logic [2:0]    fn;
	logic [7:0]    c8;
	logic [IW-1:0] cur_addr, rd_cell_addr;
	logic [RW-1:0] nl_row, set_row, cll_row;
	logic          nl_scroll;
	logic [CW-1:0] set_col;
	logic [14:0]   tab_prod;
	logic [3:0]    tab_quot, tab_cnt;
	logic [7:0]    tab_rem, tab_next;

	logic [CW-1:0] dec_col;
	logic [RW-1:0] dec_row;
	logic          dec_fill, dec_scroll, dec_wr, dec_rd, dec_use_mem;
	logic [IW-1:0] dec_fill_addr;
	logic [AW-1:0] dec_fill_cnt;
	logic [6:0]    dec_cell;

	logic          scr_rd, scr_wr, scroll_done;
	logic          wr_en, rd_en;
	logic [IW-1:0] wr_addr, rd_addr;
	logic [6:0]    wr_data;

	assign fn = s_tuser;
	assign ch = s_tdata[7:0];
	assign ca = s_tdata[15:8];
	assign ra = s_tdata[23:16];
	assign c8 = 8'(cur_col_q);

	assign cur_addr     = IW'(int'(cur_row_q) * COLS + int'(cur_col_q));
	assign rd_cell_addr = IW'(int'(ra[RW-1:0]) * COLS + int'(ca[CW-1:0]));

	// new line: next row, or stay on the last row and scroll
	assign nl_scroll = (cur_row_q == RW'(ROWS - 1));
	assign nl_row    = nl_scroll ? cur_row_q : cur_row_q + RW'(1);

	// 1-based clamp
	always_comb begin
		if (ca == 8'd0)        set_col = '0;
		else if (ca > COLS_B)  set_col = CW'(COLS - 1);
		else                   set_col = CW'(ca - 8'd1);
		if (ra == 8'd0)        set_row = '0;
		else if (ra > ROWS_B)  set_row = RW'(ROWS - 1);
		else                   set_row = RW'(ra - 8'd1);
	end
	assign cll_row = (ra != 8'd0) ? set_row : cur_row_q;

	// tab stop via reciprocal
	assign tab_prod = 15'(cur_col_q) * TAB_RECIP;
	assign tab_quot = tab_prod[14:11];
	assign tab_rem  = c8 - 8'(8'(tab_quot) * TAB_STEP);
	assign tab_cnt  = 4'(TAB_STEP - tab_rem);
	assign tab_next = c8 + 8'(tab_cnt);

	always_comb begin
		dec_col       = cur_col_q;
		dec_row       = cur_row_q;
		dec_fill      = 1'b0;
		dec_scroll    = 1'b0;
		dec_wr        = 1'b0;
		dec_rd        = 1'b0;
		dec_use_mem   = 1'b0;
		dec_fill_addr = cur_addr;
		dec_fill_cnt  = '0;
		dec_cell      = '0;
		unique case (fn)
			FN_PUT: begin
				priority if ((ch >= CHAR_FIRST) && (ch <= CHAR_TILDE)) begin
					dec_wr = 1'b1;
					if (cur_col_q == CW'(COLS - 1)) begin
						dec_col    = '0;
						dec_row    = nl_row;
						dec_scroll = nl_scroll;
					end else begin
						dec_col = cur_col_q + CW'(1);
					end
				end else if (ch == CHAR_NL) begin
					dec_col    = '0;
					dec_row    = nl_row;
					dec_scroll = nl_scroll;
				end else if (ch == CHAR_TAB) begin
					dec_fill = 1'b1;
					if (tab_next >= COLS_B) begin
						// pad to row end, then new line
						dec_fill_cnt = AW'(COLS_B - c8);
						dec_col      = '0;
						dec_row      = nl_row;
						dec_scroll   = nl_scroll;
					end else begin
						dec_fill_cnt = AW'(tab_cnt);
						dec_col      = CW'(tab_next);
					end
				end else begin
				end
			end
			FN_SETCUR: begin
				dec_col = set_col;
				dec_row = set_row;
			end
			FN_CLS: begin
				dec_col       = '0;
				dec_row       = '0;
				dec_fill      = 1'b1;
				dec_fill_addr = '0;
				dec_fill_cnt  = AW'(TOTAL);
			end
			FN_CLL: begin
				dec_row       = cll_row;
				if (ra == 8'd0) dec_col = '0;
				dec_fill      = 1'b1;
				dec_fill_addr = IW'(int'(cll_row) * COLS);
				dec_fill_cnt  = AW'(COLS);
			end
			FN_READ: begin
				priority if ((ca >= COLS_B) || (ra >= ROWS_B)) begin
					dec_cell = '0;
				end else if (ca == COLS_B - 8'd1) begin
					dec_cell = (ra < ROWS_B - 8'd1) ? CELL_NL : 7'd0;
				end else begin
					dec_rd      = 1'b1;
					dec_use_mem = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// scroll copy: read row below, write it in the following cycle
	assign scr_rd      = cmd.scroll_step && (src_q != AW'(TOTAL));
	assign scr_wr      = cmd.scroll_step && vld_s1;
	assign scroll_done = scr_wr && (src_q == AW'(TOTAL));

	always_comb begin
		priority if (scr_wr) begin
			wr_en   = 1'b1;
			wr_addr = dst_s1;
			wr_data = rdata_q;
		end else if (cmd.fill_step) begin
			wr_en   = 1'b1;
			wr_addr = fill_addr_q;
			wr_data = CELL_SPACE;
		end else begin
			wr_en   = cmd.accept && dec_wr;
			wr_addr = cur_addr;
			wr_data = ch[6:0];
		end
		rd_en   = scr_rd || (cmd.accept && dec_rd);
		rd_addr = scr_rd ? src_q[IW-1:0] : rd_cell_addr;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			fill_addr_q   <= '0;
			fill_cnt_q    <= AW'(TOTAL);
			scroll_pend_q <= 1'b0;
			src_q         <= AW'(TOTAL);
			vld_s1        <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				cur_col_q     <= dec_col;
				cur_row_q     <= dec_row;
				scroll_pend_q <= dec_scroll;
				src_q         <= AW'(COLS);
				vld_s1        <= 1'b0;
				if (dec_fill) begin
					fill_addr_q <= dec_fill_addr;
					fill_cnt_q  <= dec_fill_cnt;
				end
			end
			if (cmd.fill_step) begin
				fill_addr_q <= fill_addr_q + IW'(1);
				fill_cnt_q  <= fill_cnt_q - AW'(1);
			end
			if (cmd.scroll_step) begin
				if (scr_rd) begin
					src_q  <= src_q + AW'(1);
					vld_s1 <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
				if (scroll_done) begin
					scroll_pend_q <= 1'b0;
					fill_addr_q   <= IW'((ROWS - 1) * COLS);
					fill_cnt_q    <= AW'(COLS);
				end
			end
			if (cmd.out_load)  m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scr_rd) dst_s1 <= IW'(src_q - AW'(COLS));
		if (cmd.accept) begin
			use_mem_q <= dec_use_mem;
			cell_q    <= dec_cell;
		end
		if (cmd.out_load) begin
			m_tdata_q <= {6'b0, 5'(cur_row_q), 6'(cur_col_q), use_mem_q ? rdata_q : cell_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign stat.dec_fill    = dec_fill;
	assign stat.dec_scroll  = dec_scroll;
	assign stat.scroll_pend = scroll_pend_q;
	assign stat.fill_last   = (fill_cnt_q == AW'(1));
	assign stat.scroll_done = scroll_done;
	assign stat.out_free    = !m_tvalid_q || m_tready;

`ifndef ASSERT_OFF
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cur_col_q) < COLS) && (int'(cur_row_q) < ROWS)) else $error("cursor out of range");
	a_fill_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> (fill_cnt_q != '0)) else $error("fill with zero count");
	a_scroll_ports: assert property (@(posedge clk) disable iff (!arst_n)
		(scr_rd && scr_wr) |-> (rd_addr != wr_addr)) else $error("scroll read hits write");
`endif

endmodule

### hdl/text_terminal_screen_writer.sv
// Cursor and read commands, and prints that neither fill nor scroll, go from acceptance to the
// result phase, which loads the registered result beat; a new command is taken only after that.
// Tab, clear line and clear screen fill one cell at a time (one store write port); a scroll
// copies the rows up one cell at a time, then fills the last row with spaces.
// Reset: cursor to 0,0; a clearing pass writes ROWS*COLS spaces with s_tready low.
module text_terminal_screen_writer
	import tsw_pkg::*;
#(
	parameter int ROWS = 20,
	parameter int COLS = 61
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], col_arg[15:8], row_arg[23:16]
	input  logic [2:0]  s_tuser,   // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // cell_char[6:0], cursor_col[12:7], cursor_row[17:13], zeros
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer: decides phases from datapath status
	tsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: decode, cursor, character store and result beat register
	tsw_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

### test/text_terminal_screen_writer_test.sv
// Self-checking testbench for the text terminal screen writer: directed and random commands.
module text_terminal_screen_writer_test
	import tsw_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS  = 20;
	localparam int COLS  = 61;
	localparam int CELLS = ROWS * COLS;

	// func codes the block must treat as no-ops
	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;

	localparam int RANDOM_CMDS   = 675;
	localparam int QUIET_TAIL    = 60;   // last commands run with no idling on either side
	localparam int HOLD_EVERY    = 200;  // sender waits for a full drain this often
	localparam int STALL_LIMIT   = 20000; // cycles with no beat on either side
	localparam int REPORT_LIMIT  = 10;

	// one command as the sender sees it
	typedef struct {
		logic [2:0] func;
		logic [7:0] code;
		logic [7:0] col_arg;
		logic [7:0] row_arg;
		bit         hold;   // wait until every result is back before presenting
		bit         quiet;  // start of the no-idle tail
	} term_cmd_t;

	// result beat, laid out as m_tdata[17:0]
	typedef struct packed {
		logic [4:0] row;
		logic [5:0] col;
		logic [6:0] glyph;
	} screen_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // char_code[7:0], col_arg[15:8], row_arg[23:16]
	logic [2:0]  s_tuser = '0;   // func[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // cell_char[6:0], cursor_col[12:7], cursor_row[17:13]

	term_cmd_t      cmd_backlog[$];
	screen_result_t due_results[$];
	term_cmd_t      on_bus;
	bit             quiet_mode = 1'b0;
	int             mismatches = 0;
	int             idle_cycles = 0;

	// shadow copy of the screen store and cursor
	logic [6:0]  shadow_cells[CELLS];
	int unsigned shadow_col;
	int unsigned shadow_row;

	text_terminal_screen_writer #(
		.ROWS(ROWS),
		.COLS(COLS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// screen predictor
	// ---------------------------------------------------------------

	function automatic void blank_cells(int unsigned start, int unsigned count);
		for (int unsigned i = start; i < start + count; i++)
			if (i < CELLS)
				shadow_cells[i] = CELL_SPACE;
	endfunction

	// cursor to column 0 of the next row; scroll the store up at the bottom
	function automatic void line_feed();
		shadow_col = 0;
		shadow_row++;
		if (shadow_row >= ROWS) begin
			shadow_row = ROWS - 1;
			for (int i = 0; i < (ROWS - 1) * COLS; i++)
				shadow_cells[i] = shadow_cells[i + COLS];
			blank_cells((ROWS - 1) * COLS, COLS);
		end
	endfunction

	// 1-based argument clamped to 1..hi, returned 0-based
	function automatic int unsigned clamp_pos(logic [7:0] v, int unsigned hi);
		int unsigned x;
		x = 32'(v);
		if (x > hi) x = hi;
		if (x < 1) x = 1;
		return x - 1;
	endfunction

	function automatic screen_result_t apply_command(term_cmd_t c);
		screen_result_t r;
		int unsigned    tab_to;
		r.glyph = '0;
		case (c.func)
			FN_PUT: begin
				if (c.code >= CHAR_FIRST && c.code <= CHAR_TILDE) begin
					shadow_cells[shadow_row * COLS + shadow_col] = c.code[6:0];
					shadow_col++;
					if (shadow_col >= COLS) line_feed();
				end else if (c.code == CHAR_NL) begin
					line_feed();
				end else if (c.code == CHAR_TAB) begin
					tab_to = (shadow_col + TAB_STEP) / TAB_STEP * TAB_STEP;
					// a tab stop past the row end fills the row out and wraps
					if (tab_to >= COLS) begin
						blank_cells(shadow_row * COLS + shadow_col, COLS - shadow_col);
						line_feed();
					end else begin
						blank_cells(shadow_row * COLS + shadow_col, tab_to - shadow_col);
						shadow_col = tab_to;
					end
				end
				// everything else is ignored, cursor stays put
			end
			FN_SETCUR: begin
				shadow_col = clamp_pos(c.col_arg, COLS);
				shadow_row = clamp_pos(c.row_arg, ROWS);
			end
			FN_CLS: begin
				blank_cells(0, CELLS);
				shadow_col = 0;
				shadow_row = 0;
			end
			FN_CLL: begin
				// row 0 means the current row, column goes home
				if (c.row_arg != 0) shadow_row = clamp_pos(c.row_arg, ROWS);
				else shadow_col = 0;
				blank_cells(shadow_row * COLS, COLS);
			end
			FN_READ: begin
				// last column reads as a line break, except on the last row
				if (c.col_arg >= COLS || c.row_arg >= ROWS)
					r.glyph = '0;
				else if (c.col_arg == COLS - 1)
					r.glyph = (c.row_arg < ROWS - 1) ? CELL_NL : 7'd0;
				else
					r.glyph = shadow_cells[c.row_arg * COLS + c.col_arg];
			end
			default: ;
		endcase
		r.col = shadow_col[5:0];
		r.row = shadow_row[4:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	function automatic void queue_cmd(logic [2:0] func, logic [7:0] code,
			logic [7:0] col_arg, logic [7:0] row_arg);
		term_cmd_t c;
		c.func    = func;
		c.code    = code;
		c.col_arg = col_arg;
		c.row_arg = row_arg;
		c.hold    = 1'b0;
		c.quiet   = 1'b0;
		cmd_backlog.push_back(c);
	endfunction

	// mostly text with cursor moves and reads; clears kept rare since they walk the store
	function automatic term_cmd_t random_cmd();
		term_cmd_t c;
		int        pick;
		pick      = $urandom_range(0, 99);
		c.func    = FN_PUT;
		c.code    = 8'($urandom_range(0, 255));
		c.col_arg = 8'($urandom_range(0, 255));
		c.row_arg = 8'($urandom_range(0, 255));
		c.hold    = 1'b0;
		c.quiet   = 1'b0;
		if (pick < 50 || pick > 96) begin
			c.code = 8'($urandom_range(CHAR_FIRST, CHAR_TILDE));
		end else if (pick < 54) begin
			c.code = CHAR_NL;
		end else if (pick < 58) begin
			c.code = CHAR_TAB;
		end else if (pick < 62) begin
			// any byte, control and high codes included
		end else if (pick < 72) begin
			c.func = FN_SETCUR;
			if ($urandom_range(0, 3) != 0) begin
				c.col_arg = 8'($urandom_range(1, COLS));
				c.row_arg = 8'($urandom_range(1, ROWS));
			end
		end else if (pick < 77) begin
			c.func = FN_CLL;
			case ($urandom_range(0, 2))
				0: c.row_arg = 8'd0;
				1: c.row_arg = 8'($urandom_range(1, ROWS));
				default: ;
			endcase
		end else if (pick < 94) begin
			c.func = FN_READ;
			if ($urandom_range(0, 4) != 0) begin
				c.col_arg = 8'($urandom_range(0, COLS - 1));
				c.row_arg = 8'($urandom_range(0, ROWS - 1));
			end
		end else if (pick < 95) begin
			c.func = FN_CLS;
		end else begin
			c.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		end
		return c;
	endfunction

	initial begin : stimulus_p
		term_cmd_t c;

		// store comes out of reset as all spaces, cursor home
		for (int i = 0; i < CELLS; i++)
			shadow_cells[i] = CELL_SPACE;
		shadow_col = 0;
		shadow_row = 0;

		// directed: character extremes, ignored codes, tab and wrap corners, scrolls
		queue_cmd(FN_READ,   8'd0,       8'd0,      8'd0);
		queue_cmd(FN_PUT,    CHAR_FIRST, 8'd0,      8'd0);
		queue_cmd(FN_PUT,    CHAR_TILDE, 8'd0,      8'd0);
		queue_cmd(FN_PUT,    8'd31,      8'd0,      8'd0);
		queue_cmd(FN_PUT,    8'd127,     8'd0,      8'd0);
		queue_cmd(FN_PUT,    8'd255,     8'd255,    8'd255);
		queue_cmd(FN_PUT,    8'd0,       8'd0,      8'd0);
		queue_cmd(FN_PUT,    CHAR_TAB,   8'd0,      8'd0);
		queue_cmd(FN_PUT,    CHAR_NL,    8'd0,      8'd0);
		queue_cmd(FN_SETCUR, 8'd0,       8'd0,      8'd0);
		queue_cmd(FN_SETCUR, 8'd0,       8'd255,    8'd255);
		queue_cmd(FN_PUT,    8'd90,      8'd0,      8'd0);   // last cell: wrap and scroll
		queue_cmd(FN_READ,   8'd0,       8'(COLS - 1), 8'(ROWS - 2));
		queue_cmd(FN_READ,   8'd0,       8'(COLS - 1), 8'(ROWS - 1));
		queue_cmd(FN_READ,   8'd0,       8'd1,      8'(ROWS - 2));
		queue_cmd(FN_SETCUR, 8'd0,       8'(COLS - 2), 8'd1);
		queue_cmd(FN_PUT,    CHAR_TAB,   8'd0,      8'd0);   // lands on the last stop
		queue_cmd(FN_PUT,    CHAR_TAB,   8'd0,      8'd0);   // past the row end: wrap
		queue_cmd(FN_SETCUR, 8'd0,       8'd1,      8'(ROWS));
		queue_cmd(FN_PUT,    CHAR_NL,    8'd0,      8'd0);   // scroll on newline
		queue_cmd(FN_CLL,    8'd0,       8'd0,      8'd0);
		queue_cmd(FN_CLL,    8'd0,       8'd0,      8'd3);
		queue_cmd(FN_CLL,    8'd0,       8'd0,      8'd255);
		queue_cmd(FN_READ,   8'd0,       8'(COLS),  8'd0);
		queue_cmd(FN_READ,   8'd0,       8'd0,      8'(ROWS));
		queue_cmd(FN_READ,   8'd0,       8'd255,    8'd255);
		queue_cmd(FN_SPARE_LO, 8'd255,   8'd255,    8'd255);
		queue_cmd(FN_SPARE_HI, 8'd0,     8'd0,      8'd0);
		queue_cmd(FN_CLS,    8'd0,       8'd0,      8'd0);
		queue_cmd(FN_READ,   8'd0,       8'd0,      8'd0);

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			c       = random_cmd();
			c.hold  = (i % HOLD_EVERY == 0);
			c.quiet = (i == RANDOM_CMDS - QUIET_TAIL);
			cmd_backlog.push_back(c);
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		// anything still owed counts against the run
		mismatches += due_results.size();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------
	// command driver
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_p
		int gap_left;
		bit fired;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			gap_left = 0;
		end else begin
			fired = s_tvalid && s_tready;
			if (fired) begin
				due_results.push_back(apply_command(on_bus));
				if (!quiet_mode && $urandom_range(0, 5) == 0)
					gap_left = $urandom_range(1, 9);
			end
			if (s_tvalid && !fired) begin
				// beat still pending, hold it
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (cmd_backlog.size() == 0
					|| (cmd_backlog[0].hold && due_results.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else begin
				on_bus = cmd_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {on_bus.row_arg, on_bus.col_arg, on_bus.code};
				s_tuser  <= on_bus.func;
				if (on_bus.quiet) quiet_mode <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : sink_p
		int             stall_left;
		screen_result_t want;
		screen_result_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[17:0];
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%t: result beat with nothing pending: glyph %0d col %0d row %0d",
							$realtime, got.glyph, got.col, got.row);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%t: want glyph %0d col %0d row %0d, got glyph %0d col %0d row %0d",
								$realtime, want.glyph, want.col, want.row,
								got.glyph, got.col, got.row);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: the stall limit sits well above any scroll or clear, so this is generous
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
